/* rtl/core/b64se_pkg.sv */
package b64se_pkg;

	localparam int CfgIndexW = 2;

	localparam logic [CfgIndexW-1:0] CFG_URL_ALPHABET      = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_PADDING_ENABLED   = 2'd1;
	localparam logic [CfgIndexW-1:0] CFG_MULTILINE_ENABLED = 2'd2;

	localparam logic [6:0] CHAR_EQUALS  = 7'h3D;
	localparam logic [6:0] CHAR_NEWLINE = 7'h0A;

	function automatic logic [6:0] sextet_char(input logic [5:0] v, input logic url);
		logic [6:0] ch;
		logic [6:0] vx;
		vx = {1'b0, v};
		if (v < 6'd26) begin
			ch = 7'h41 + vx;
		end else if (v < 6'd52) begin
			ch = 7'h47 + vx;
		end else if (v < 6'd62) begin
			ch = vx - 7'd4;
		end else if (v == 6'd62) begin
			ch = url ? 7'h2D : 7'h2B;
		end else begin
			ch = url ? 7'h5F : 7'h2F;
		end
		return ch;
	endfunction

endpackage

/* rtl/core/base64_stream_encoder_unit.sv */
// Streaming base64 encoder: one message byte per data word in, one ASCII character per char
// word out (standard or URL-safe alphabet, optional '=' padding to a multiple of four,
// optional newline after every LINE_LENGTH characters, none after the last). last_char marks
// the final character of each message. A byte sits in one input stage register and is
// turned into output words there, one word per cycle while the receiver keeps char_ready
// high, into a single output register. The next byte is taken in the same cycle its
// predecessor's final word is loaded, so the sustained rate is the output rate of one
// word per cycle without stalls. Configuration writes are meant for idle periods and
// apply from the next character.
module base64_stream_encoder_unit
	import b64se_pkg::*;
#(
	parameter int LINE_LENGTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_enable,
	input  logic [CfgIndexW-1:0] reg_index,
	input  logic                 write_data,
	input  logic                 data_valid,
	output logic                 data_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 char_valid,
	input  logic                 char_ready,
	output logic [6:0]           character,
	output logic                 last_char
);

	localparam int CountMod = (LINE_LENGTH % 4 == 0) ? LINE_LENGTH : 4 * LINE_LENGTH;
	localparam int CountW   = $clog2(CountMod);
	localparam int Line1    = LINE_LENGTH % CountMod;
	localparam int Line2    = (2 * LINE_LENGTH) % CountMod;
	localparam int Line3    = (3 * LINE_LENGTH) % CountMod;

	logic url_q, pad_q, ml_q;

	logic [3:0]        residue_q;
	logic [2:0]        rcount_q;
	logic [CountW-1:0] count_q;
	logic              any_q;

	logic        valid_s1;
	logic [11:0] acc_s1;
	logic [3:0]  nbits_s1;
	logic        last_s1;
	logic        nl_done_s1;

	logic [6:0] char_q;
	logic       last_q;
	logic       out_valid_q;

	logic              at_line, nl_need, is_data, is_flush, more;
	logic              slot_free, step, finish, accept;
	logic [3:0]        nbits_nxt;
	logic [CountW-1:0] count_inc;
	logic [6:0]        real_char;

	always_comb begin
		at_line = (count_q == CountW'(0)) || (count_q == CountW'(Line1)) ||
			(count_q == CountW'(Line2)) || (count_q == CountW'(Line3));
		nl_need   = ml_q && any_q && at_line && !nl_done_s1;
		is_data   = nbits_s1 >= 4'd6;
		is_flush  = !is_data && (nbits_s1 != 4'd0);
		real_char = (is_data || is_flush) ? sextet_char(acc_s1[11:6], url_q) : CHAR_EQUALS;
		nbits_nxt = is_data ? nbits_s1 - 4'd6 : 4'd0;
		count_inc = (count_q == CountW'(CountMod - 1)) ? '0 : count_q + 1'b1;
		more      = (nbits_nxt >= 4'd6) ||
			(last_s1 && ((nbits_nxt != 4'd0) || (pad_q && (count_inc[1:0] != 2'd0))));
		slot_free  = !out_valid_q || char_ready;
		step       = valid_s1 && slot_free;
		finish     = step && !nl_need && !more;
		data_ready = !valid_s1 || finish;
		accept     = data_valid && data_ready;
	end

	assign char_valid = out_valid_q;
	assign character  = char_q;
	assign last_char  = last_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_q <= 1'b0;
			pad_q <= 1'b1;
			ml_q  <= 1'b0;
		end else if (write_enable) begin
			case (reg_index)
				CFG_URL_ALPHABET:      url_q <= write_data;
				CFG_PADDING_ENABLED:   pad_q <= write_data;
				CFG_MULTILINE_ENABLED: ml_q  <= write_data;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (char_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			char_q <= nl_need ? CHAR_NEWLINE : real_char;
			last_q <= !nl_need && !more && last_s1;
		end
	end

	// stage 1 control and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			nl_done_s1 <= 1'b0;
			count_q    <= '0;
			any_q      <= 1'b0;
			residue_q  <= 4'd0;
			rcount_q   <= 3'd0;
		end else begin
			if (step && !nl_need) begin
				if (finish && last_s1) begin
					count_q <= '0;
					any_q   <= 1'b0;
				end else begin
					count_q <= count_inc;
					any_q   <= 1'b1;
				end
			end
			if (accept) begin
				valid_s1   <= 1'b1;
				nl_done_s1 <= 1'b0;
				if (last_byte) begin
					residue_q <= 4'd0;
					rcount_q  <= 3'd0;
				end else if (rcount_q == 3'd0) begin
					residue_q <= {2'b00, data_byte[1:0]};
					rcount_q  <= 3'd2;
				end else if (rcount_q == 3'd2) begin
					residue_q <= data_byte[3:0];
					rcount_q  <= 3'd4;
				end else begin
					residue_q <= 4'd0;
					rcount_q  <= 3'd0;
				end
			end else begin
				if (finish) begin
					valid_s1 <= 1'b0;
				end
				if (step) begin
					nl_done_s1 <= nl_need;
				end
			end
		end
	end

	// stage 1 payload: bits kept left-aligned, next sextet in acc_s1[11:6]
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last_byte;
			if (rcount_q == 3'd0) begin
				acc_s1   <= {data_byte, 4'b0000};
				nbits_s1 <= 4'd8;
			end else if (rcount_q == 3'd2) begin
				acc_s1   <= {residue_q[1:0], data_byte, 2'b00};
				nbits_s1 <= 4'd10;
			end else begin
				acc_s1   <= {residue_q, data_byte};
				nbits_s1 <= 4'd12;
			end
		end else if (step && !nl_need) begin
			acc_s1   <= {acc_s1[5:0], 6'b000000};
			nbits_s1 <= nbits_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_newline_only_multiline: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (character != CHAR_NEWLINE) || ml_q)
		else $error("newline emitted with multiline mode off");

	a_last_not_newline: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && last_char |-> character != CHAR_NEWLINE)
		else $error("message ends in a newline");

	a_residue_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rcount_q == 3'd0) || (rcount_q == 3'd2) || (rcount_q == 3'd4))
		else $error("bad residue count");

	a_padding_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step && !nl_need && !is_data && !is_flush |-> pad_q && (count_q[1:0] != 2'd0))
		else $error("pad character outside padding phase");
`endif

endmodule

/* tb/tb_b64_char_check_pkg.sv */
package tb_b64_char_check_pkg;

	import b64se_pkg::*;

	localparam int LINE_LEN  = 64;
	localparam int COUNT_MOD = (LINE_LEN % 4 == 0) ? LINE_LEN : 4 * LINE_LEN;

	class encoded_char_scoreboard;

		typedef struct packed {
			logic [6:0] ch;
			logic       is_last;
		} char_word_t;

		char_word_t expected_chars[$];
		bit         url_alphabet;
		bit         padding_enabled;
		bit         multiline_enabled;
		logic [3:0] residue_bits;
		int         residue_count;
		int         char_count;
		bit         any_char;
		int         errors;

		function new();
			url_alphabet      = 1'b0;
			padding_enabled   = 1'b1;
			multiline_enabled = 1'b0;
			residue_bits      = '0;
			residue_count     = 0;
			char_count        = 0;
			any_char          = 1'b0;
			errors            = 0;
		endfunction

		function void set_reg(logic [CfgIndexW-1:0] idx, bit val);
			case (idx)
				CFG_URL_ALPHABET:      url_alphabet = val;
				CFG_PADDING_ENABLED:   padding_enabled = val;
				CFG_MULTILINE_ENABLED: multiline_enabled = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

		function logic [6:0] sextet_to_ascii(logic [5:0] v);
			if (v < 6'd26) begin
				return 7'h41 + v;
			end else if (v < 6'd52) begin
				return 7'h61 + (v - 7'd26);
			end else if (v < 6'd62) begin
				return 7'h30 + (v - 7'd52);
			end else if (v == 6'd62) begin
				return url_alphabet ? 7'h2D : 7'h2B;
			end
			return url_alphabet ? 7'h5F : 7'h2F;
		endfunction

		function void add_char(logic [6:0] ch);
			char_word_t w;
			if (multiline_enabled && any_char && (char_count % LINE_LEN) == 0) begin
				w.ch      = CHAR_NEWLINE;
				w.is_last = 1'b0;
				expected_chars.push_back(w);
			end
			w.ch      = ch;
			w.is_last = 1'b0;
			expected_chars.push_back(w);
			char_count = (char_count + 1) % COUNT_MOD;
			any_char   = 1'b1;
		endfunction

		// one accepted input word -> expected output words
		function void encode_byte(logic [7:0] data, logic is_last);
			logic [11:0] acc;
			logic [11:0] low;
			logic [11:0] sx;
			int          nbits;
			char_word_t  w;
			acc   = {residue_bits, data};
			nbits = residue_count + 8;
			while (nbits >= 6) begin
				nbits -= 6;
				sx = acc >> nbits;
				add_char(sextet_to_ascii(sx[5:0]));
			end
			low = acc & ((12'd1 << nbits) - 12'd1);
			if (is_last) begin
				if (nbits != 0) begin
					sx = low << (6 - nbits);
					add_char(sextet_to_ascii(sx[5:0]));
				end
				if (padding_enabled) begin
					while ((char_count % 4) != 0) begin
						add_char(CHAR_EQUALS);
					end
				end
				w         = expected_chars.pop_back();
				w.is_last = 1'b1;
				expected_chars.push_back(w);
				residue_bits  = '0;
				residue_count = 0;
				char_count    = 0;
				any_char      = 1'b0;
			end else begin
				residue_bits  = low[3:0];
				residue_count = nbits;
			end
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_char(logic [6:0] ch, logic is_last);
			char_word_t want;
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, is_last));
				return;
			end
			want = expected_chars.pop_front();
			if (ch !== want.ch) begin
				report_mismatch($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
			end
			if (is_last !== want.is_last) begin
				report_mismatch($sformatf("last_char %0b, want %0b (char 0x%02h)",
					is_last, want.is_last, want.ch));
			end
		endtask

	endclass

endpackage

/* tb/tb_base64_stream_encoder_unit.sv */
module tb_base64_stream_encoder_unit;

	import b64se_pkg::*;
	import tb_b64_char_check_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 write_enable;
	logic [CfgIndexW-1:0] reg_index;
	logic                 write_data;
	logic                 data_valid;
	logic                 data_ready;
	logic [7:0]           data_byte;
	logic                 last_byte;
	logic                 char_valid;
	logic                 char_ready;
	logic [6:0]           character;
	logic                 last_char;

	encoded_char_scoreboard sb = new();

	bit no_gaps     = 1'b0;
	int hold_cycles = 0;
	int msg_left    = 0;

	base64_stream_encoder_unit #(
		.LINE_LENGTH(LINE_LEN)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_enable(write_enable),
		.reg_index   (reg_index),
		.write_data  (write_data),
		.data_valid  (data_valid),
		.data_ready  (data_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.character   (character),
		.last_char   (last_char)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (no_gaps) begin
			return 0;
		end
		r = $urandom_range(0, 15);
		if (r < 9) begin
			return 0;
		end else if (r < 14) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic int next_msg_len(bit want_long);
		int r;
		if (want_long) begin
			return $urandom_range(48, 70);
		end
		r = $urandom_range(0, 19);
		if (r < 14) begin
			return $urandom_range(1, 6);
		end else if (r < 18) begin
			return $urandom_range(7, 24);
		end
		return $urandom_range(48, 70);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= b;
		last_byte  <= is_last;
		@(posedge clk);
		while (!data_ready) @(posedge clk);
		sb.encode_byte(b, is_last);
	endtask

	task automatic drain();
		data_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input bit url, input bit pad, input bit multi);
		logic [CfgIndexW-1:0] idx [3];
		bit                   val [3];
		idx = '{CFG_URL_ALPHABET, CFG_PADDING_ENABLED, CFG_MULTILINE_ENABLED};
		val = '{url, pad, multi};
		for (int i = 0; i < 3; i++) begin
			write_enable <= 1'b1;
			reg_index    <= idx[i];
			write_data   <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		write_enable <= 1'b0;
	endtask

	task automatic run_phase(input bit url, input bit pad, input bit multi, input int n,
		input bit quiet, input bit hold);
		bit long_done;
		drain();
		program_regs(url, pad, multi);
		no_gaps   = quiet;
		long_done = 1'b0;
		if (hold) begin
			hold_cycles = LONG_HOLD;
		end
		repeat (n) begin
			if (msg_left == 0) begin
				msg_left  = next_msg_len(multi && !long_done);
				long_done = long_done | multi;
			end
			send_byte(8'($urandom_range(0, 255)), msg_left == 1);
			msg_left--;
		end
		no_gaps = 1'b0;
	endtask

	// receiver side
	initial begin
		int g;
		char_ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_cycles > 0) begin
				char_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				if (!char_ready) begin
					char_ready <= 1'b1;
				end
				repeat ($urandom_range(1, 12)) @(posedge clk);
				g = pick_gap();
				if (g > 0) begin
					char_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_valid && char_ready) begin
			sb.check_char(character, last_char);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((data_valid && data_ready) || (char_valid && char_ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n       <= 1'b0;
		write_enable <= 1'b0;
		reg_index    <= CFG_URL_ALPHABET;
		write_data   <= 1'b0;
		data_valid   <= 1'b0;
		data_byte    <= '0;
		last_byte    <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: standard alphabet, padded, single line
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'h78, 1'b1);
		// settings change in the middle of a message
		send_byte(8'hFB, 1'b0);
		send_byte(8'hFF, 1'b0);
		drain();
		program_regs(1'b1, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b1);

		run_phase(1'b0, 1'b1, 1'b1, 35, 1'b0, 1'b1);
		run_phase(1'b1, 1'b0, 1'b1, 30, 1'b0, 1'b0);
		run_phase(1'b1, 1'b1, 1'b0, 20, 1'b1, 1'b0);
		run_phase(1'b0, 1'b0, 1'b0, 20, 1'b0, 1'b0);
		run_phase(1'b1, 1'b1, 1'b1, 35, 1'b0, 1'b0);
		drain();
		repeat (20) @(posedge clk);

		if (sb.pending() != 0) begin
			sb.report_mismatch($sformatf("%0d chars never arrived", sb.pending()));
		end
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* base64_stream_encoder_unit.f */
rtl/core/b64se_pkg.sv
rtl/core/base64_stream_encoder_unit.sv
tb/tb_b64_char_check_pkg.sv
tb/tb_base64_stream_encoder_unit.sv
